@@ sv/tccw_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package tccw_pkg;

  // Screen geometry
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int COPY_LEN   = CELL_COUNT - COLUMNS;

  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLUMNS);

  // Character and attribute codes
  localparam logic [7:0]  NEWLINE_CODE = 8'd10;
  localparam logic [7:0]  SPACE_CODE   = 8'h20;
  localparam logic [7:0]  ATTR_RESET   = 8'h07;
  localparam logic [15:0] RESET_CELL   = {ATTR_RESET, SPACE_CODE};

  // Operation codes
  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Configuration port
  localparam int          CFG_ADDR_W    = 3;
  localparam logic        REG_SEL_ATTR  = 1'b0;

  typedef struct packed {
    logic        operation;
    logic [7:0]  char_code;
    logic [10:0] read_index;
  } in_req_t;

  typedef struct packed {
    logic [15:0] cell_value;
    logic [4:0]  cursor_row_out;
    logic [6:0]  cursor_col_out;
  } out_result_t;

  // Memory traffic and status of the sweep unit
  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [15:0]       wr_data;
    logic              done;
  } sweep_req_t;

endpackage

`default_nettype wire

@@ sv/tccw_cell_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tccw_cell_ram (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [tccw_pkg::ADDR_W-1:0] waddr,
  input  wire logic [15:0]                 wdata,
  input  wire logic                        re,
  input  wire logic [tccw_pkg::ADDR_W-1:0] raddr,
  output logic      [15:0]                 rdata
);

  logic [15:0] mem [tccw_pkg::CELL_COUNT];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ sv/tccw_sweep.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tccw_sweep (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 go,
  input  wire logic [7:0]           blank_attr,
  input  wire logic [15:0]          ram_rdata,
  output tccw_pkg::sweep_req_t      req
);

  logic                          active_r;
  logic                          clear_r;
  logic [tccw_pkg::ADDR_W-1:0]   cnt_r;
  logic                          wr_en_r;
  logic [tccw_pkg::ADDR_W-1:0]   wr_addr_r;
  logic                          wr_copy_r;
  logic [15:0]                   wr_blank_r;
  logic                          copy_phase;
  logic                          last_cnt;

  assign copy_phase = !clear_r && (cnt_r < tccw_pkg::ADDR_W'(tccw_pkg::COPY_LEN));
  assign last_cnt   = (cnt_r == tccw_pkg::ADDR_W'(tccw_pkg::CELL_COUNT - 1));

  always_comb begin
    req.rd_en   = active_r && copy_phase;
    req.rd_addr = cnt_r + tccw_pkg::ADDR_W'(tccw_pkg::COLUMNS);
    req.wr_en   = wr_en_r;
    req.wr_addr = wr_addr_r;
    req.wr_data = wr_copy_r ? ram_rdata : wr_blank_r;
    req.done    = wr_en_r && !active_r;
  end

  // Reset starts a clearing pass; go starts a one-line scroll.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b1;
      clear_r  <= 1'b1;
      cnt_r    <= '0;
      wr_en_r  <= 1'b0;
    end else begin
      if (go) begin
        active_r <= 1'b1;
        clear_r  <= 1'b0;
        cnt_r    <= '0;
      end else if (active_r) begin
        cnt_r <= cnt_r + tccw_pkg::ADDR_W'(1);
        if (last_cnt) begin
          active_r <= 1'b0;
        end
      end
      wr_en_r <= active_r;
    end
  end

  // Write stage: lines up with the registered read data
  always_ff @(posedge clk) begin
    wr_addr_r  <= cnt_r;
    wr_copy_r  <= copy_phase;
    wr_blank_r <= clear_r ? tccw_pkg::RESET_CELL : {blank_attr, tccw_pkg::SPACE_CODE};
  end

endmodule

`default_nettype wire

@@ sv/text_console_cell_writer.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports                              Handshake
// -------   --------------------------------   ----------------------------------
// request   start, busy, in_req                taken when start is high, busy low
// result    out_valid, out_result              one-cycle strobe, cannot stall
// config    cfg_psel .. cfg_pready (APB)       written on access phase, no waits
//
// For a put that does not scroll, the cell (unless the code is a newline) is written
// at the accept edge and the result strobes in the next cycle, with busy staying low.
// A read waits in S_READ for the registered read port of the cell memory.
// A put that scrolls holds busy while the sweep walks every cell once, writing
// one cell per cycle and, outside the last row, reading the cell one row below.
// After reset a clearing pass over every cell holds busy high;
// configuration writes are taken during it.
module text_console_cell_writer (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // request channel
  input  wire logic                            start,
  output logic                                 busy,
  input  wire tccw_pkg::in_req_t               in_req,
  // result channel
  output logic                                 out_valid,
  output tccw_pkg::out_result_t                out_result,
  // configuration port
  input  wire logic                            cfg_psel,
  input  wire logic                            cfg_penable,
  input  wire logic                            cfg_pwrite,
  input  wire logic [tccw_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [31:0]                     cfg_pwdata,
  output logic      [31:0]                     cfg_prdata,
  output logic                                 cfg_pready
);

  typedef enum logic [3:0] {
    S_CLEAR  = 4'b0001,
    S_IDLE   = 4'b0010,
    S_READ   = 4'b0100,
    S_SCROLL = 4'b1000
  } state_t;

  state_t                         state_r, state_nxt;
  logic [7:0]                     attr_r;
  logic [tccw_pkg::ROW_W-1:0]     row_r, row_nxt;
  logic [tccw_pkg::COL_W-1:0]     col_r, col_nxt;
  logic [tccw_pkg::ADDR_W-1:0]    base_r, base_nxt;   // row_r * COLUMNS
  logic [15:0]                    cell_r;
  logic                           out_valid_r;
  logic                           rd_ok_r;

  logic                           accept;
  logic                           is_put;
  logic                           is_newline;
  logic                           at_line_end;
  logic                           at_last_row;
  logic                           line_feed;
  logic                           scroll_go;
  logic                           put_we;
  logic [tccw_pkg::ADDR_W-1:0]    put_addr;
  logic                           rd_issue;
  logic                           rd_in_range;
  logic                           cfg_wr;

  tccw_pkg::sweep_req_t           sweep;
  logic                           ram_we;
  logic [tccw_pkg::ADDR_W-1:0]    ram_waddr;
  logic [15:0]                    ram_wdata;
  logic                           ram_re;
  logic [tccw_pkg::ADDR_W-1:0]    ram_raddr;
  logic [15:0]                    ram_rdata;

  // ---------------------------------------------------------------------------
  // Configuration port: one register, the text attribute
  // ---------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == tccw_pkg::REG_SEL_ATTR) ? {24'b0, attr_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= tccw_pkg::ATTR_RESET;
    end else if (cfg_wr && (cfg_paddr[2] == tccw_pkg::REG_SEL_ATTR)) begin
      attr_r <= cfg_pwdata[7:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Request decode
  // ---------------------------------------------------------------------------
  assign busy        = (state_r != S_IDLE);
  assign accept      = start && !busy;
  assign is_put      = (in_req.operation == tccw_pkg::OP_PUT);
  assign is_newline  = (in_req.char_code == tccw_pkg::NEWLINE_CODE);
  assign at_line_end = (col_r == tccw_pkg::COL_W'(tccw_pkg::COLUMNS - 1));
  assign at_last_row = (row_r == tccw_pkg::ROW_W'(tccw_pkg::ROWS - 1));

  // Drop to the next row on newline or on wrap past the line end
  assign line_feed = is_newline || at_line_end;
  assign scroll_go = accept && is_put && line_feed && at_last_row;

  // Write the character straight at the accept edge so a following read sees it
  assign put_we   = accept && is_put && !is_newline;
  assign put_addr = base_r + tccw_pkg::ADDR_W'(col_r);

  assign rd_in_range = (32'(in_req.read_index) < 32'(tccw_pkg::CELL_COUNT));
  assign rd_issue    = accept && !is_put && rd_in_range;

  // ---------------------------------------------------------------------------
  // Cursor update
  // ---------------------------------------------------------------------------
  always_comb begin
    row_nxt  = row_r;
    col_nxt  = col_r;
    base_nxt = base_r;
    if (accept && is_put) begin
      if (line_feed) begin
        col_nxt = '0;
        // On the last row the row holds; the grid scrolls instead.
        if (!at_last_row) begin
          row_nxt  = row_r + tccw_pkg::ROW_W'(1);
          base_nxt = base_r + tccw_pkg::ADDR_W'(tccw_pkg::COLUMNS);
        end
      end else begin
        col_nxt = col_r + tccw_pkg::COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      base_r <= '0;
    end else begin
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      base_r <= base_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (sweep.done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (!is_put) begin
            state_nxt = S_READ;
          end else if (scroll_go) begin
            state_nxt = S_SCROLL;
          end
        end
      end
      S_READ: begin
        state_nxt = S_IDLE;
      end
      S_SCROLL: begin
        if (sweep.done) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (accept && is_put && !scroll_go)
                  || (state_r == S_READ)
                  || ((state_r == S_SCROLL) && sweep.done);
    end
  end

  // Result cell: zero for a put, memory data for a read in range
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_ok_r <= rd_in_range;
    end
    if (accept && is_put) begin
      cell_r <= 16'h0000;
    end else if (state_r == S_READ) begin
      cell_r <= rd_ok_r ? ram_rdata : 16'h0000;
    end
  end

  // The cursor holds while the result strobes, so it is read from the registers.
  assign out_valid                 = out_valid_r;
  assign out_result.cell_value     = cell_r;
  assign out_result.cursor_row_out = 5'(row_r);
  assign out_result.cursor_col_out = 7'(col_r);

  // ---------------------------------------------------------------------------
  // Sweep unit and cell memory
  // ---------------------------------------------------------------------------
  tccw_sweep u_sweep (
    .clk        (clk),
    .rst_n      (rst_n),
    .go         (scroll_go),
    .blank_attr (attr_r),
    .ram_rdata  (ram_rdata),
    .req        (sweep)
  );

  // The sweep and the request side never drive the memory in the same cycle.
  assign ram_we    = sweep.wr_en || put_we;
  assign ram_waddr = sweep.wr_en ? sweep.wr_addr : put_addr;
  assign ram_wdata = sweep.wr_en ? sweep.wr_data : {attr_r, in_req.char_code};
  assign ram_re    = sweep.rd_en || rd_issue;
  assign ram_raddr = sweep.rd_en ? sweep.rd_addr
                                 : tccw_pkg::ADDR_W'(in_req.read_index);

  tccw_cell_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_write_port_free: assert property (@(posedge clk) disable iff (!rst_n)
    sweep.wr_en |-> !put_we)
    else $error("sweep write collides with character write");

  a_read_port_free: assert property (@(posedge clk) disable iff (!rst_n)
    sweep.rd_en |-> !rd_issue)
    else $error("sweep read collides with cell read");

  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (state_r == S_IDLE))
    else $error("result strobe outside idle");

  a_request_answered: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (out_valid || busy))
    else $error("accepted request neither answered nor in progress");

  a_cursor_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(row_r) < 32'(tccw_pkg::ROWS)) && (32'(col_r) < 32'(tccw_pkg::COLUMNS))
    && (base_r == tccw_pkg::ADDR_W'(32'(row_r) * tccw_pkg::COLUMNS)))
    else $error("cursor outside the grid or row base out of step");

endmodule

`default_nettype wire
